### hw/rtl/tdpt_pkg.sv
`default_nettype none

package tdpt_pkg;

  // Default width of the candidate number.
  localparam int NUM_WIDTH_DEF = 32;

  // Sequencer to remainder unit.
  typedef struct packed {
    logic start;
  } rem_ctl_t;

  // Remainder unit back to the sequencer.
  typedef struct packed {
    logic done;
    logic rem_zero;
  } rem_sts_t;

endpackage

`default_nettype wire

### hw/rtl/tdpt_rem_unit.sv
`default_nettype none

// Bit-serial restoring remainder: one dividend bit per cycle.
// The quotient is not kept.
module tdpt_rem_unit #(
  parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF,
  parameter int DIV_WIDTH = (NUM_WIDTH + 1) / 2 + 1
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  tdpt_pkg::rem_ctl_t      ctl,
  input  wire  [NUM_WIDTH-1:0]    dividend,
  input  wire  [DIV_WIDTH-1:0]    divisor,
  output tdpt_pkg::rem_sts_t      sts
);
  import tdpt_pkg::*;

  localparam int CNT_WIDTH = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [DIV_WIDTH-1:0] rem_r, rem_nxt;
  logic [NUM_WIDTH-1:0] dvd_r, dvd_nxt;
  logic [DIV_WIDTH-1:0] dsr_r, dsr_nxt;
  logic [DIV_WIDTH:0]   trial;

  // The remainder stays below the divisor, so one extra bit covers the shifted value.
  assign trial = {rem_r, dvd_r[NUM_WIDTH-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_WIDTH'(NUM_WIDTH - 1);
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIV_WIDTH'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[DIV_WIDTH-1:0];
      end
      dvd_nxt = {dvd_r[NUM_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_WIDTH'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  always_comb begin
    sts.done     = done_r;
    sts.rem_zero = (rem_r == '0);
  end

endmodule

`default_nettype wire

### hw/rtl/trial_division_prime_test.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_ready | in_candidate [NUM_WIDTH-1:0], unsigned
// out     | output    | out_valid/out_ready | out_is_prime, 1 bit
//
// Zero and one go straight to the result, two and three after a single check
// of 2 squared against them. Otherwise each divisor tried (2, then odd numbers
// while its square fits) costs one full division in the bit-serial remainder
// unit, so a 32-bit prime near the top needs about 32768 divisions.
// in_ready is high only while no test runs; a result waiting in the output
// register does not block a new transaction. rst_n is synchronous, active low.
`default_nettype none

module trial_division_prime_test #(
  parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [NUM_WIDTH-1:0] in_candidate,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic                 out_is_prime
);
  import tdpt_pkg::*;

  localparam int DIV_WIDTH = (NUM_WIDTH + 1) / 2 + 1;
  localparam int SQ_WIDTH  = NUM_WIDTH + 2;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [NUM_WIDTH-1:0] num_r, num_nxt;
  logic [DIV_WIDTH-1:0] div_r, div_nxt;
  logic [SQ_WIDTH-1:0]  sq_r, sq_nxt;
  logic                 res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_prime_r, out_prime_nxt;
  rem_ctl_t             rem_ctl;
  rem_sts_t             rem_sts;

  tdpt_rem_unit #(
    .NUM_WIDTH (NUM_WIDTH),
    .DIV_WIDTH (DIV_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rem_ctl),
    .dividend (num_r),
    .divisor  (div_r),
    .sts      (rem_sts)
  );

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    rem_ctl.start = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          num_nxt = in_candidate;
          div_nxt = DIV_WIDTH'(2);
          sq_nxt  = SQ_WIDTH'(4);
          if (in_candidate < NUM_WIDTH'(2)) begin
            res_nxt   = 1'b0;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // sq_r always holds div_r squared, kept up by adding 4d+4 per odd step.
        if (sq_r > {2'b00, num_r}) begin
          res_nxt   = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          rem_ctl.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_sts.done) begin
          if (rem_sts.rem_zero) begin
            res_nxt   = 1'b0;
            state_nxt = ST_FINISH;
          end else begin
            if (div_r == DIV_WIDTH'(2)) begin
              div_nxt = DIV_WIDTH'(3);
              sq_nxt  = SQ_WIDTH'(9);
            end else begin
              div_nxt = div_r + DIV_WIDTH'(2);
              sq_nxt  = sq_r + SQ_WIDTH'({div_r, 2'b00}) + SQ_WIDTH'(4);
            end
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r       <= num_nxt;
    div_r       <= div_nxt;
    sq_r        <= sq_nxt;
    res_r       <= res_nxt;
    out_prime_r <= out_prime_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/tdpt_checker.sv
`default_nettype none

module tdpt_checker #(
  parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire [NUM_WIDTH-1:0] in_candidate,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire                 out_is_prime
);

  logic in_acc;
  logic out_free;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before the transaction completed");

  a_out_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_is_prime))
    else $error("out_is_prime changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("in_ready stayed high after an input transaction");

  a_zero_one_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && out_free && (in_candidate == '0 || in_candidate == NUM_WIDTH'(1))
    |=> ##1 (out_valid && !out_is_prime))
    else $error("zero or one not reported as composite");

  a_two_three_prime: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && out_free && (in_candidate == NUM_WIDTH'(2) || in_candidate == NUM_WIDTH'(3))
    |=> ##2 (out_valid && out_is_prime))
    else $error("two or three not reported as prime");

endmodule

bind trial_division_prime_test tdpt_checker #(
  .NUM_WIDTH (NUM_WIDTH)
) u_tdpt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_candidate (in_candidate),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_is_prime (out_is_prime)
);

`default_nettype wire
